// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== rtl/rhm_pkg.sv =====
// Package: types, constants and tables of the mobility step block
`timescale 1ns / 1ps
package rhm_pkg;
    localparam int CORDIC_ITERS_DEF = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam int CFG_AW = 5;

    typedef enum logic [2:0] {
        REG_MOVE_INTERVAL = 3'd0,
        REG_SPEED_MIN     = 3'd1,
        REG_SPEED_MAX     = 3'd2,
        REG_X_LOWER       = 3'd3,
        REG_X_UPPER       = 3'd4,
        REG_Y_LOWER       = 3'd5,
        REG_Y_UPPER       = 3'd6,
        REG_NONE          = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ROT, ST_DISP, ST_WRAP, ST_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] cur_x;
        logic [15:0] cur_y;
        logic [15:0] heading;
        logic [15:0] speed;
    } t_job;

    typedef struct packed {
        logic [15:0] move_interval;
        logic [15:0] x_lower;
        logic [15:0] x_upper;
        logic [15:0] y_lower;
        logic [15:0] y_upper;
    } t_cfg;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
                5'd20: r = 32'd652;       5'd21: r = 32'd326;
                5'd22: r = 32'd163;       5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            atan_turn = r;
        end
    endfunction
endpackage

// ===== rtl/rhm_if.sv =====
// Valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
interface rhm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic signed [15:0] heading_delta;
    logic [15:0] speed_fraction;
    modport source(output valid, cur_x, cur_y, heading_delta, speed_fraction, input ready);
    modport sink(input valid, cur_x, cur_y, heading_delta, speed_fraction, output ready);
endinterface

interface rhm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_x;
    logic [15:0] new_y;
    logic signed [16:0] step_dx;
    logic signed [16:0] step_dy;
    logic        wrapped;
    modport source(output valid, new_x, new_y, step_dx, step_dy, wrapped, input ready);
    modport sink(input valid, new_x, new_y, step_dx, step_dy, wrapped, output ready);
endinterface

// ===== rtl/rhm_front.sv =====
// Front end: keeps the heading, forms the speed and queues jobs
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rhm_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhm_in_if.sink      in_ch,
    input  logic [15:0] i_speed_min,
    input  logic [15:0] i_speed_max,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output rhm_pkg::t_job o_job
);
    // two-entry queue
    rhm_pkg::t_job r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [15:0]   r_heading;
    logic [15:0]   n_heading;
    logic [15:0]   span;
    logic [31:0]   prod;
    logic [15:0]   n_speed;
    logic          push, pop;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop = o_job_valid && i_job_ready;
    assign o_job = r_q[r_rp];

    assign n_heading = r_heading + in_ch.heading_delta;
    assign span = (i_speed_max >= i_speed_min) ? (i_speed_max - i_speed_min)
                                                : (i_speed_min - i_speed_max);
    assign prod = span * in_ch.speed_fraction;
    assign n_speed = (i_speed_max >= i_speed_min) ? (i_speed_min + prod[31:16])
                                                   : (i_speed_min - prod[31:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_heading <= 16'd0;
        end else begin
            if (push) begin
                r_heading <= n_heading;
                r_wp <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cur_x: in_ch.cur_x, cur_y: in_ch.cur_y,
                           heading: n_heading, speed: n_speed};
        end
    end

    `CHK_IMPL(a_no_over, i_clk, i_rst_n, r_cnt == 2'd2, !push)
    `CHK_IMPL(a_cnt_rng, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `CHK_NEXT(a_hd_keep, i_clk, i_rst_n, !push, r_heading == $past(r_heading))
endmodule

// ===== rtl/rhm_back.sv =====
// Back end: distance multiply, CORDIC rotation, displacement and wrap
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rhm_back #(
    parameter int CORDIC_ITERS = rhm_pkg::CORDIC_ITERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  rhm_pkg::t_job i_job,
    input  rhm_pkg::t_cfg i_cfg,
    rhm_out_if.source     out_ch
);
    localparam int NIT = (CORDIC_ITERS < rhm_pkg::ATAN_ENTRIES) ? CORDIC_ITERS
                                                               : rhm_pkg::ATAN_ENTRIES;
    localparam logic [4:0] LAST = 5'(NIT - 1);

    rhm_pkg::t_state r_st, n_st;
    rhm_pkg::t_job   r_job;
    logic [31:0]     r_dist;
    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]      r_it;
    logic            r_flip;
    logic signed [16:0] r_dx, r_dy;
    logic [15:0]     r_nx, r_ny;
    logic            r_wr;

    logic [31:0]     ang;
    logic signed [33:0] xs, ys, at, zx, zy;
    logic signed [66:0] px, py;
    logic signed [20:0] tx, ty;
    logic signed [17:0] vx, vy;
    logic            hx1, hx2, hy1, hy2;
    logic signed [18:0] sx, sy;
    logic [15:0]     wx1, wy1;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            rhm_pkg::ST_IDLE: if (i_job_valid) n_st = rhm_pkg::ST_MUL;
            rhm_pkg::ST_MUL:  n_st = rhm_pkg::ST_ROT;
            rhm_pkg::ST_ROT:  if (r_it == LAST) n_st = rhm_pkg::ST_DISP;
            rhm_pkg::ST_DISP: n_st = rhm_pkg::ST_WRAP;
            rhm_pkg::ST_WRAP: n_st = rhm_pkg::ST_OUT;
            rhm_pkg::ST_OUT:  if (out_ch.ready) n_st = rhm_pkg::ST_IDLE;
            default:          n_st = rhm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready  = (r_st == rhm_pkg::ST_IDLE);
        out_ch.valid = (r_st == rhm_pkg::ST_OUT);
    end
    assign out_ch.new_x = r_nx;
    assign out_ch.new_y = r_ny;
    assign out_ch.step_dx = r_dx;
    assign out_ch.step_dy = r_dy;
    assign out_ch.wrapped = r_wr;

    assign ang = {i_job.heading ^ ((i_job.heading[15] ^ i_job.heading[14]) ?
                  16'h8000 : 16'h0000), 16'h0000};
    assign xs = r_x >>> r_it;
    assign ys = r_y >>> r_it;
    assign at = $signed({2'b00, rhm_pkg::atan_turn(r_it)});

    // final vector, negated for a half-turn start
    assign zx = r_flip ? -r_x : r_x;
    assign zy = r_flip ? -r_y : r_y;
    assign px = $signed({1'b0, r_dist}) * zx;
    assign py = $signed({1'b0, r_dist}) * zy;
    assign tx = (px < 0) ? -21'((-px) >>> 46) : 21'(px >>> 46);
    assign ty = (py < 0) ? -21'((-py) >>> 46) : 21'(py >>> 46);
    assign vx = (tx > 21'sd65535) ? 18'sd65535 : (tx < -21'sd65535) ? -18'sd65535 : 18'(tx);
    assign vy = (ty > 21'sd65535) ? 18'sd65535 : (ty < -21'sd65535) ? -18'sd65535 : 18'(ty);

    assign sx = $signed({3'b000, r_job.cur_x}) + 19'(r_dx);
    assign sy = $signed({3'b000, r_job.cur_y}) + 19'(r_dy);
    assign hx1 = sx < $signed({3'b000, i_cfg.x_lower});
    assign wx1 = hx1 ? i_cfg.x_upper : sx[15:0];
    assign hx2 = hx1 ? 1'b0 : (sx > $signed({3'b000, i_cfg.x_upper}));
    assign hy1 = sy < $signed({3'b000, i_cfg.y_lower});
    assign wy1 = hy1 ? i_cfg.y_upper : sy[15:0];
    assign hy2 = hy1 ? 1'b0 : (sy > $signed({3'b000, i_cfg.y_upper}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= rhm_pkg::ST_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            rhm_pkg::ST_IDLE: begin
                r_job  <= i_job;
                r_flip <= i_job.heading[15] ^ i_job.heading[14];
                r_z    <= $signed({{2{ang[31]}}, ang});
                r_x    <= rhm_pkg::CORDIC_START;
                r_y    <= '0;
                r_it   <= '0;
            end
            rhm_pkg::ST_MUL: r_dist <= i_cfg.move_interval * r_job.speed;
            rhm_pkg::ST_ROT: begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + at;
                end
                r_it <= r_it + 5'd1;
            end
            rhm_pkg::ST_DISP: begin
                r_dx <= 17'(vx);
                r_dy <= 17'(vy);
            end
            rhm_pkg::ST_WRAP: begin
                r_nx <= hx2 ? i_cfg.x_lower : wx1;
                r_ny <= hy2 ? i_cfg.y_lower : wy1;
                r_wr <= hx1 | hx2 | hy1 | hy2;
            end
            default: ;
        endcase
    end

    `CHK_IMPL(a_rdy_idle, i_clk, i_rst_n, o_job_ready, !out_ch.valid)
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `CHK_IMPL(a_it_rng, i_clk, i_rst_n, r_st == rhm_pkg::ST_ROT, r_it <= LAST)
endmodule

// ===== rtl/random_heading_mobility_step_top.sv =====
// Top level: APB registers, front end, job queue and back end
`timescale 1ns / 1ps
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    cur_x cur_y heading_delta speed_fraction
//  out_ch    out  valid/ready    new_x new_y step_dx step_dy wrapped
//  apb       in   psel/penable   7 x 16-bit registers at 4*i
// One word at a time passes through the back end's multiply, CORDIC loop, displacement and wrap steps.
// The front end queues two words while the back end works or stalls.
// Reset is synchronous, active low; heading clears to zero.
// A stalled result holds the back end until taken.
module random_heading_mobility_step_top #(
    parameter int CORDIC_ITERS = rhm_pkg::CORDIC_ITERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhm_in_if.sink      in_ch,
    rhm_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rhm_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_mi, r_smin, r_smax, r_xl, r_xu, r_yl, r_yu;
    rhm_pkg::t_reg_idx idx;
    rhm_pkg::t_cfg cfg;
    rhm_pkg::t_job job;
    logic job_valid, job_ready;

    assign pready = 1'b1;
    assign idx = (paddr[1:0] == 2'b00) ? rhm_pkg::t_reg_idx'(paddr[4:2]) : rhm_pkg::REG_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mi <= 16'd256; r_smin <= 16'd0; r_smax <= 16'd2560;
            r_xl <= 16'd0; r_xu <= 16'd1000; r_yl <= 16'd0; r_yu <= 16'd1000;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                rhm_pkg::REG_MOVE_INTERVAL: r_mi <= pwdata[15:0];
                rhm_pkg::REG_SPEED_MIN:     r_smin <= pwdata[15:0];
                rhm_pkg::REG_SPEED_MAX:     r_smax <= pwdata[15:0];
                rhm_pkg::REG_X_LOWER:       r_xl <= pwdata[15:0];
                rhm_pkg::REG_X_UPPER:       r_xu <= pwdata[15:0];
                rhm_pkg::REG_Y_LOWER:       r_yl <= pwdata[15:0];
                rhm_pkg::REG_Y_UPPER:       r_yu <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rhm_pkg::REG_MOVE_INTERVAL: prdata = {16'd0, r_mi};
            rhm_pkg::REG_SPEED_MIN:     prdata = {16'd0, r_smin};
            rhm_pkg::REG_SPEED_MAX:     prdata = {16'd0, r_smax};
            rhm_pkg::REG_X_LOWER:       prdata = {16'd0, r_xl};
            rhm_pkg::REG_X_UPPER:       prdata = {16'd0, r_xu};
            rhm_pkg::REG_Y_LOWER:       prdata = {16'd0, r_yl};
            rhm_pkg::REG_Y_UPPER:       prdata = {16'd0, r_yu};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg = '{move_interval: r_mi, x_lower: r_xl, x_upper: r_xu,
                   y_lower: r_yl, y_upper: r_yu};

    rhm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .i_speed_min(r_smin), .i_speed_max(r_smax),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    rhm_back #(.CORDIC_ITERS(CORDIC_ITERS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid),
        .o_job_ready(job_ready), .i_job(job), .i_cfg(cfg), .out_ch(out_ch)
    );
endmodule
